/* src/crpr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpr_pkg : shared types and constants of the cosmic ray pixel rejector
// Register map, configuration and control structs, command codes.
// ----------------------------------------------------------------------------
package crpr_pkg;

    // Configuration port geometry
    localparam int unsigned CFG_ADDR_BITS = 5;
    localparam int unsigned CFG_DATA_BITS = 32;

    // Fixed field widths of the registers
    localparam int unsigned WIDTH_BITS  = 12;
    localparam int unsigned HEIGHT_BITS = 16;
    localparam int unsigned ROW_BITS    = 17;  // input row runs to height + 1 while draining
    localparam int unsigned THR_BITS    = 32;
    localparam int unsigned NEIGH_BITS  = 4;

    // Register reset values
    localparam logic [WIDTH_BITS-1:0]  IMAGE_WIDTH_RST  = 12'd2048;
    localparam logic [HEIGHT_BITS-1:0] IMAGE_HEIGHT_RST = 16'd2048;
    localparam logic [THR_BITS-1:0]    CENTRE_THR_RST   = 32'h0000_0000;
    localparam logic [THR_BITS-1:0]    SURROUND_THR_RST = 32'h0000_0000;
    localparam logic [NEIGH_BITS-1:0]  MIN_GOOD_RST     = 4'd4;
    localparam logic [THR_BITS-1:0]    MAGIC_RST        = 32'h8000_0000;

    // Input command codes
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Register indexes (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_CENTRE_THR    = 3'd2,
        REG_SURROUND_THR  = 3'd3,
        REG_MIN_GOOD      = 3'd4,
        REG_MAGIC_VALUE   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [WIDTH_BITS-1:0]      image_width;
        logic [HEIGHT_BITS-1:0]     image_height;
        logic signed [THR_BITS-1:0] centre_threshold;
        logic signed [THR_BITS-1:0] surround_threshold;
        logic [NEIGH_BITS-1:0]      min_good_neighbours;
        logic signed [THR_BITS-1:0] magic_value;
    } t_cfg;

    // Per-item control that travels with a pixel down the pipeline
    typedef struct packed {
        logic flush;      // no new bottom pixel, line stores untouched
        logic emit;       // this item releases a judged pixel
        logic col_lo_ok;  // left neighbour column lies in the image
        logic col_hi_ok;  // right neighbour column lies in the image
        logic row_lo_ok;  // upper neighbour row lies in the image
        logic row_hi_ok;  // lower neighbour row lies in the image
        logic last;       // judged pixel is the final one of the image
    } t_ctrl;

endpackage

/* src/cosmic_ray_pixel_rejector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosmic_ray_pixel_rejector : 3x3 neighbour-threshold cosmic ray rejection
// Raster pixel stream in, same stream out with cosmic ray hits blanked.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+----------------------------------
//  pixel in  | in        | i_valid / o_ready  | i_command, i_pixel_in
//  pixel out | out       | o_valid / i_ready  | o_pixel_out, o_was_replaced,
//            |           |                    | o_last_of_image
//  config    | in        | psel/penable/pready| paddr, pwdata, pwrite, prdata
//
//  One transfer per clock while the output is not stalled; the transfer that
//  releases a result passes the line store read, window and output registers.
//  Output lags input by one row plus one pixel; width+1 flush transfers after
//  the last pixel drain the image.
//  Synchronous active-low reset clears counters, window and valid flags;
//  line stores are not cleared, so no clearing pass is needed.
//  A stalled output fills the window and read stages; o_ready drops only
//  once both are held.
// ----------------------------------------------------------------------------
module cosmic_ray_pixel_rejector #(
    parameter int MAX_WIDTH  = 2048,
    parameter int PIXEL_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // pixel input channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_command,
    input  logic signed [PIXEL_BITS-1:0]        i_pixel_in,
    // result channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [PIXEL_BITS-1:0]        o_pixel_out,
    output logic                                o_was_replaced,
    output logic                                o_last_of_image,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [crpr_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [crpr_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [crpr_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                                pready
);

    localparam int CW = $clog2(MAX_WIDTH);

    crpr_pkg::t_cfg               w_cfg;
    crpr_pkg::t_ctrl              w_in_ctrl;
    crpr_pkg::t_ctrl              w_s1_ctrl;
    logic [CW-1:0]                w_idx;
    logic                         w_accept;
    logic                         w_active;
    logic                         w_load;
    logic                         w_s1_free;
    logic                         w_s1_move;
    logic                         w_s2_free;
    logic signed [PIXEL_BITS-1:0] w_top;
    logic signed [PIXEL_BITS-1:0] w_mid;
    logic signed [PIXEL_BITS-1:0] w_bot;

    // Take a transfer whenever the read stage is empty or moving on
    assign o_ready  = w_s1_free;
    assign w_accept = i_valid && o_ready;
    // Ignored transfers (stray pixel, early or idle flush) leave no trace
    assign w_load   = w_accept && w_active;

    crpr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    crpr_seq #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_accept  (w_accept),
        .i_command (i_command),
        .o_active  (w_active),
        .o_ctrl    (w_in_ctrl),
        .o_idx     (w_idx)
    );

    crpr_line_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_lines (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_load),
        .i_s2_free (w_s2_free),
        .i_idx     (w_idx),
        .i_pixel   (i_pixel_in),
        .i_ctrl    (w_in_ctrl),
        .o_s1_free (w_s1_free),
        .o_s1_move (w_s1_move),
        .o_ctrl    (w_s1_ctrl),
        .o_top     (w_top),
        .o_mid     (w_mid),
        .o_bot     (w_bot)
    );

    crpr_judge #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_judge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_ready         (i_ready),
        .i_s1_move       (w_s1_move),
        .i_s1_ctrl       (w_s1_ctrl),
        .i_top           (w_top),
        .i_mid           (w_mid),
        .i_bot           (w_bot),
        .o_s2_free       (w_s2_free),
        .o_valid         (o_valid),
        .o_pixel_out     (o_pixel_out),
        .o_was_replaced  (o_was_replaced),
        .o_last_of_image (o_last_of_image)
    );

endmodule

/* src/crpr_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpr_cfg_regs : configuration register file
// APB-style write and read of the six configuration registers.
// ----------------------------------------------------------------------------
module crpr_cfg_regs (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [crpr_pkg::CFG_ADDR_BITS-1:0]    paddr,
    input  logic [crpr_pkg::CFG_DATA_BITS-1:0]    pwdata,
    output logic [crpr_pkg::CFG_DATA_BITS-1:0]    prdata,
    output logic                                  pready,
    output crpr_pkg::t_cfg                        o_cfg
);

    crpr_pkg::t_cfg   r_cfg;
    crpr_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = crpr_pkg::t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width         <= crpr_pkg::IMAGE_WIDTH_RST;
            r_cfg.image_height        <= crpr_pkg::IMAGE_HEIGHT_RST;
            r_cfg.centre_threshold    <= crpr_pkg::CENTRE_THR_RST;
            r_cfg.surround_threshold  <= crpr_pkg::SURROUND_THR_RST;
            r_cfg.min_good_neighbours <= crpr_pkg::MIN_GOOD_RST;
            r_cfg.magic_value         <= crpr_pkg::MAGIC_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                crpr_pkg::REG_IMAGE_WIDTH:  r_cfg.image_width <=
                    pwdata[crpr_pkg::WIDTH_BITS-1:0];
                crpr_pkg::REG_IMAGE_HEIGHT: r_cfg.image_height <=
                    pwdata[crpr_pkg::HEIGHT_BITS-1:0];
                crpr_pkg::REG_CENTRE_THR:   r_cfg.centre_threshold <=
                    pwdata[crpr_pkg::THR_BITS-1:0];
                crpr_pkg::REG_SURROUND_THR: r_cfg.surround_threshold <=
                    pwdata[crpr_pkg::THR_BITS-1:0];
                crpr_pkg::REG_MIN_GOOD:     r_cfg.min_good_neighbours <=
                    pwdata[crpr_pkg::NEIGH_BITS-1:0];
                crpr_pkg::REG_MAGIC_VALUE:  r_cfg.magic_value <=
                    pwdata[crpr_pkg::THR_BITS-1:0];
                default: ;  // drop writes beyond the map
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            crpr_pkg::REG_IMAGE_WIDTH:  prdata = 32'(r_cfg.image_width);
            crpr_pkg::REG_IMAGE_HEIGHT: prdata = 32'(r_cfg.image_height);
            crpr_pkg::REG_CENTRE_THR:   prdata = 32'(unsigned'(r_cfg.centre_threshold));
            crpr_pkg::REG_SURROUND_THR: prdata = 32'(unsigned'(r_cfg.surround_threshold));
            crpr_pkg::REG_MIN_GOOD:     prdata = 32'(r_cfg.min_good_neighbours);
            crpr_pkg::REG_MAGIC_VALUE:  prdata = 32'(unsigned'(r_cfg.magic_value));
            default:                    prdata = '0;
        endcase
    end

endmodule

/* src/crpr_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpr_seq : raster position sequencer
// Tracks input and output positions, qualifies each transfer and builds
// the control word that travels with it.
// ----------------------------------------------------------------------------
module crpr_seq #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  crpr_pkg::t_cfg                i_cfg,
    input  logic                          i_accept,
    input  logic                          i_command,
    output logic                          o_active,
    output crpr_pkg::t_ctrl               o_ctrl,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_idx
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;
    localparam int RB = crpr_pkg::ROW_BITS;
    localparam int HB = crpr_pkg::HEIGHT_BITS;

    logic [CW-1:0] r_in_col;
    logic [RB-1:0] r_in_row;
    logic [CW-1:0] r_out_col;
    logic [HB-1:0] r_out_row;

    logic [WW-1:0] w_eff_w;
    logic [HB-1:0] w_eff_h;
    logic [RB-1:0] w_h_ext;
    logic [WW-1:0] w_col_inc;
    logic [WW-1:0] w_ocol_inc;
    logic [RB-1:0] w_orow_inc;
    logic          w_col_wrap;
    logic          w_ocol_wrap;
    logic          w_orow_last;
    logic          w_emit;
    logic          w_last;
    logic          w_flush;

    always_comb begin
        if (i_cfg.image_width == '0) begin
            w_eff_w = WW'(1);
        end else if (32'(i_cfg.image_width) > 32'(MAX_WIDTH)) begin
            w_eff_w = WW'(MAX_WIDTH);
        end else begin
            w_eff_w = WW'(i_cfg.image_width);
        end
    end

    assign w_eff_h     = (i_cfg.image_height == '0) ? HB'(1) : i_cfg.image_height;
    assign w_h_ext     = RB'(w_eff_h);
    assign w_flush     = (i_command == crpr_pkg::CMD_FLUSH);

    assign w_col_inc   = WW'(r_in_col) + WW'(1);
    assign w_col_wrap  = (w_col_inc >= w_eff_w);
    assign w_ocol_inc  = WW'(r_out_col) + WW'(1);
    assign w_ocol_wrap = (w_ocol_inc >= w_eff_w);
    assign w_orow_inc  = RB'(r_out_row) + RB'(1);
    assign w_orow_last = (w_orow_inc >= w_h_ext);

    // Pixels count only while rows remain, flushes only once all rows are in
    assign o_active = w_flush ? (r_in_row >= w_h_ext) : (r_in_row < w_h_ext);

    assign w_emit = (r_in_row >= RB'(2)) || ((r_in_row == RB'(1)) && (r_in_col != '0));
    assign w_last = w_orow_last && w_ocol_wrap;

    assign o_idx            = r_in_col;
    assign o_ctrl.flush     = w_flush;
    assign o_ctrl.emit      = w_emit;
    assign o_ctrl.col_lo_ok = (r_out_col != '0);
    assign o_ctrl.col_hi_ok = !w_ocol_wrap;
    assign o_ctrl.row_lo_ok = (r_out_row != '0);
    assign o_ctrl.row_hi_ok = !w_orow_last;
    assign o_ctrl.last      = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (i_accept && o_active) begin
            if (w_emit && w_last) begin
                // end of image: start the next one from the top
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                if (w_col_wrap) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + RB'(1);
                end else begin
                    r_in_col <= w_col_inc[CW-1:0];
                end
                if (w_emit) begin
                    if (w_ocol_wrap) begin
                        r_out_col <= '0;
                        r_out_row <= w_orow_inc[HB-1:0];
                    end else begin
                        r_out_col <= w_ocol_inc[CW-1:0];
                    end
                end
            end
        end
    end

endmodule

/* src/crpr_line_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpr_line_store : upper and middle line memories with read stage
// Reads both lines on transfer, writes them back as the item moves on, and
// forwards a write that lands on the address being read in the same cycle.
// ----------------------------------------------------------------------------
module crpr_line_store #(
    parameter int MAX_WIDTH  = 2048,
    parameter int PIXEL_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_load,
    input  logic                                 i_s2_free,
    input  logic [$clog2(MAX_WIDTH)-1:0]         i_idx,
    input  logic signed [PIXEL_BITS-1:0]         i_pixel,
    input  crpr_pkg::t_ctrl                      i_ctrl,
    output logic                                 o_s1_free,
    output logic                                 o_s1_move,
    output crpr_pkg::t_ctrl                      o_ctrl,
    output logic signed [PIXEL_BITS-1:0]         o_top,
    output logic signed [PIXEL_BITS-1:0]         o_mid,
    output logic signed [PIXEL_BITS-1:0]         o_bot
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic signed [PIXEL_BITS-1:0] mem_upper  [MAX_WIDTH];
    logic signed [PIXEL_BITS-1:0] mem_middle [MAX_WIDTH];

    logic                         r_s1_valid;
    crpr_pkg::t_ctrl              r_s1_ctrl;
    logic [CW-1:0]                r_s1_idx;
    logic signed [PIXEL_BITS-1:0] r_s1_pix;
    logic signed [PIXEL_BITS-1:0] r_rd_upper;
    logic signed [PIXEL_BITS-1:0] r_rd_middle;
    logic                         r_byp;
    logic signed [PIXEL_BITS-1:0] r_fwd_upper;
    logic signed [PIXEL_BITS-1:0] r_fwd_middle;

    logic                         w_write;

    assign o_s1_move = r_s1_valid && i_s2_free;
    assign o_s1_free = !r_s1_valid || i_s2_free;
    assign w_write   = o_s1_move && !r_s1_ctrl.flush;

    assign o_top  = r_byp ? r_fwd_upper  : r_rd_upper;
    assign o_mid  = r_byp ? r_fwd_middle : r_rd_middle;
    assign o_bot  = r_s1_ctrl.flush ? '0 : r_s1_pix;
    assign o_ctrl = r_s1_ctrl;

    // Line memories: read on transfer, write as the item leaves the stage
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rd_upper  <= mem_upper[i_idx];
            r_rd_middle <= mem_middle[i_idx];
        end
        if (w_write) begin
            mem_upper[r_s1_idx]  <= o_mid;
            mem_middle[r_s1_idx] <= r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s1_free) begin
            r_s1_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1_ctrl    <= i_ctrl;
            r_s1_idx     <= i_idx;
            r_s1_pix     <= i_pixel;
            r_byp        <= w_write && (r_s1_idx == i_idx);
            r_fwd_upper  <= o_mid;
            r_fwd_middle <= r_s1_pix;
        end
    end

endmodule

/* src/crpr_judge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpr_judge : 3x3 window, cosmic ray decision and output register
// Shifts the window, counts good neighbours and registers the result.
// ----------------------------------------------------------------------------
module crpr_judge #(
    parameter int PIXEL_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  crpr_pkg::t_cfg                i_cfg,
    input  logic                          i_ready,
    input  logic                          i_s1_move,
    input  crpr_pkg::t_ctrl               i_s1_ctrl,
    input  logic signed [PIXEL_BITS-1:0]  i_top,
    input  logic signed [PIXEL_BITS-1:0]  i_mid,
    input  logic signed [PIXEL_BITS-1:0]  i_bot,
    output logic                          o_s2_free,
    output logic                          o_valid,
    output logic signed [PIXEL_BITS-1:0]  o_pixel_out,
    output logic                          o_was_replaced,
    output logic                          o_last_of_image
);

    localparam int CMPW = (PIXEL_BITS > 32) ? PIXEL_BITS : 32;

    logic signed [PIXEL_BITS-1:0] r_win [3][3];
    logic                         r_s2_valid;
    crpr_pkg::t_ctrl              r_s2_ctrl;
    logic                         r_out_valid;
    logic signed [PIXEL_BITS-1:0] r_out_pix;
    logic                         r_out_repl;
    logic                         r_out_last;

    logic                         w_out_free;
    logic signed [CMPW-1:0]       w_magic;
    logic signed [CMPW-1:0]       w_surround;
    logic signed [CMPW-1:0]       w_centre_thr;
    logic signed [CMPW-1:0]       w_centre;
    logic [2:0]                   w_row_ok;
    logic [2:0]                   w_col_ok;
    logic [8:0]                   w_good;
    logic [3:0]                   w_good_cnt;
    logic                         w_cand;
    logic                         w_repl;

    assign w_out_free = !r_out_valid || i_ready;
    assign o_s2_free  = !r_s2_valid || w_out_free;

    assign w_magic      = CMPW'(i_cfg.magic_value);
    assign w_surround   = CMPW'(i_cfg.surround_threshold);
    assign w_centre_thr = CMPW'(i_cfg.centre_threshold);
    assign w_centre     = CMPW'(r_win[1][1]);

    assign w_row_ok = {r_s2_ctrl.row_hi_ok, 1'b1, r_s2_ctrl.row_lo_ok};
    assign w_col_ok = {r_s2_ctrl.col_hi_ok, 1'b1, r_s2_ctrl.col_lo_ok};

    // Good neighbour: inside the image, not blank, below the surround level
    always_comb begin
        logic signed [CMPW-1:0] v;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                v = CMPW'(r_win[r][c]);
                w_good[r*3+c] = w_row_ok[r] && w_col_ok[c] && !(r == 1 && c == 1)
                                && (v != w_magic) && (v < w_surround);
            end
        end
    end

    assign w_good_cnt = 4'($countones(w_good));
    assign w_cand     = (w_centre != w_magic) && (w_centre >= w_centre_thr);
    assign w_repl     = w_cand && (w_good_cnt >= i_cfg.min_good_neighbours);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (i_s1_move) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= i_top;
            r_win[1][2] <= i_mid;
            r_win[2][2] <= i_bot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s2_free) begin
                r_s2_valid <= i_s1_move && i_s1_ctrl.emit;
            end
            if (w_out_free) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s2_free && i_s1_move) begin
            r_s2_ctrl <= i_s1_ctrl;
        end
        if (w_out_free && r_s2_valid) begin
            r_out_pix  <= w_repl ? PIXEL_BITS'(i_cfg.magic_value) : r_win[1][1];
            r_out_repl <= w_repl;
            r_out_last <= r_s2_ctrl.last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_pixel_out     = r_out_pix;
    assign o_was_replaced  = r_out_repl;
    assign o_last_of_image = r_out_last;

endmodule

/* tb/crpr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpr_checker : judged-pixel predictor and scoreboard for the pixel rejector
// Watches the pixel, result and register channels, works out every judged
// pixel from its own line stores and window, and compares field by field.
// ----------------------------------------------------------------------------
module crpr_checker #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_px_valid,
    input  logic                                i_px_ready,
    input  logic                                i_px_command,
    input  logic signed [31:0]                  i_px_data,
    input  logic                                i_res_valid,
    input  logic                                i_res_ready,
    input  logic signed [31:0]                  i_res_pixel,
    input  logic                                i_res_replaced,
    input  logic                                i_res_last,
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic                                i_pready,
    input  logic [crpr_pkg::CFG_ADDR_BITS-1:0]  i_paddr,
    input  logic [crpr_pkg::CFG_DATA_BITS-1:0]  i_pwdata,
    output int                                  o_pending,
    output int                                  o_errors
);

    typedef struct packed {
        logic signed [31:0] pixel;
        logic               replaced;
        logic               last;
    } t_judged_px;

    crpr_pkg::t_cfg     cfg;
    logic signed [31:0] upper_row  [MAX_WIDTH];
    logic signed [31:0] middle_row [MAX_WIDTH];
    logic signed [31:0] win [3][3];
    int unsigned        in_col, in_row, out_col, out_row;
    t_judged_px         judged_q [$];
    int                 mismatch_cnt = 0;

    assign o_errors = mismatch_cnt;

    task automatic report_mismatch(input string msg);
        $display("t=%0t: %s", $time, msg);
        mismatch_cnt++;
    endtask

    // Advance line stores, window and counters by one transfer; queue the
    // judged pixel that leaves, if any.
    task automatic judge_transfer(input logic cmd, input logic signed [31:0] pix);
        int unsigned        w, h, idx, good;
        logic signed [31:0] top_px, mid_px, bot_px, centre, c_thr, s_thr, magic;
        logic               emit, hit, last;
        int                 nr, nc;
        t_judged_px         res;
        w = (cfg.image_width == 0) ? 1 :
            (cfg.image_width > MAX_WIDTH) ? MAX_WIDTH : cfg.image_width;
        h = (cfg.image_height == 0) ? 1 : cfg.image_height;
        c_thr = cfg.centre_threshold;
        s_thr = cfg.surround_threshold;
        magic = cfg.magic_value;

        // drop pixels while draining, and flushes before the image is in
        if (cmd == crpr_pkg::CMD_PIXEL && in_row >= h) return;
        if (cmd == crpr_pkg::CMD_FLUSH && in_row < h) return;

        idx    = (in_col < MAX_WIDTH) ? in_col : MAX_WIDTH - 1;
        top_px = upper_row[idx];
        mid_px = middle_row[idx];
        bot_px = (cmd == crpr_pkg::CMD_FLUSH) ? '0 : pix;
        if (cmd == crpr_pkg::CMD_PIXEL) begin
            upper_row[idx]  = mid_px;
            middle_row[idx] = bot_px;
        end
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = top_px;
        win[1][2] = mid_px;
        win[2][2] = bot_px;

        emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
        if (in_col + 1 >= w) begin
            in_col = 0;
            in_row++;
        end else begin
            in_col++;
        end
        if (!emit) return;

        centre = win[1][1];
        hit    = 1'b0;
        if (centre != magic && centre >= c_thr) begin
            good = 0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    nr = int'(out_row) + r - 1;
                    nc = int'(out_col) + c - 1;
                    if (nr < 0 || nr >= int'(h) || nc < 0 || nc >= int'(w)) continue;
                    if (r == 1 && c == 1) continue;
                    if (win[r][c] == magic) continue;
                    if (win[r][c] < s_thr) good++;
                end
            end
            hit = (good >= cfg.min_good_neighbours);
        end

        last = (out_row + 1 >= h) && (out_col + 1 >= w);
        if (last) begin
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
        end else if (out_col + 1 >= w) begin
            out_col = 0;
            out_row++;
        end else begin
            out_col++;
        end

        res.pixel    = hit ? magic : centre;
        res.replaced = hit;
        res.last     = last;
        judged_q.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_judged_px want;
        if (!i_rst_n) begin
            cfg.image_width         = crpr_pkg::IMAGE_WIDTH_RST;
            cfg.image_height        = crpr_pkg::IMAGE_HEIGHT_RST;
            cfg.centre_threshold    = crpr_pkg::CENTRE_THR_RST;
            cfg.surround_threshold  = crpr_pkg::SURROUND_THR_RST;
            cfg.min_good_neighbours = crpr_pkg::MIN_GOOD_RST;
            cfg.magic_value         = crpr_pkg::MAGIC_RST;
            for (int i = 0; i < MAX_WIDTH; i++) begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    win[r][c] = '0;
                end
            end
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
            judged_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (crpr_pkg::t_reg_idx'(i_paddr[4:2]))
                    crpr_pkg::REG_IMAGE_WIDTH:
                        cfg.image_width = i_pwdata[crpr_pkg::WIDTH_BITS-1:0];
                    crpr_pkg::REG_IMAGE_HEIGHT:
                        cfg.image_height = i_pwdata[crpr_pkg::HEIGHT_BITS-1:0];
                    crpr_pkg::REG_CENTRE_THR:
                        cfg.centre_threshold = i_pwdata;
                    crpr_pkg::REG_SURROUND_THR:
                        cfg.surround_threshold = i_pwdata;
                    crpr_pkg::REG_MIN_GOOD:
                        cfg.min_good_neighbours = i_pwdata[crpr_pkg::NEIGH_BITS-1:0];
                    crpr_pkg::REG_MAGIC_VALUE:
                        cfg.magic_value = i_pwdata;
                    default: ;
                endcase
            end
            if (i_px_valid && i_px_ready) begin
                judge_transfer(i_px_command, i_px_data);
            end
            if (i_res_valid && i_res_ready) begin
                if (judged_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, pixel_out %h",
                                              i_res_pixel));
                end else begin
                    want = judged_q.pop_front();
                    if (i_res_pixel !== want.pixel)
                        report_mismatch($sformatf("pixel_out got %h, predicted %h",
                                                  i_res_pixel, want.pixel));
                    if (i_res_replaced !== want.replaced)
                        report_mismatch($sformatf("was_replaced got %b, predicted %b",
                                                  i_res_replaced, want.replaced));
                    if (i_res_last !== want.last)
                        report_mismatch($sformatf("last_of_image got %b, predicted %b",
                                                  i_res_last, want.last));
                end
            end
        end
        o_pending <= judged_q.size();
    end

endmodule

/* tb/cosmic_ray_pixel_rejector_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosmic_ray_pixel_rejector_test : stimulus and verdict for the pixel rejector
// Streams whole images with noise transfers through the block under random
// sender gaps and receiver stalls, reprogramming the thresholds and geometry
// between images; a checker alongside predicts and compares every result.
// ----------------------------------------------------------------------------
module cosmic_ray_pixel_rejector_test;

    localparam int QUIET_LIMIT   = 2000;  // cycles without any transfer
    localparam int RANDOM_ITEMS  = 500;

    // Directed levels, 16.16: centre threshold 16.0, surround 1.0
    localparam logic [31:0] CENTRE_LEVEL   = 32'h0010_0000;
    localparam logic [31:0] SURROUND_LEVEL = 32'h0001_0000;
    localparam logic [31:0] HOT_PX         = 32'h0040_0000;
    localparam logic [31:0] COLD_PX        = 32'h0000_8000;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        px_valid   = 1'b0;
    logic        px_command = crpr_pkg::CMD_PIXEL;
    logic [31:0] px_data    = '0;
    logic        px_ready;

    logic        res_valid;
    logic        res_ready  = 1'b0;
    logic [31:0] res_pixel;
    logic        res_replaced;
    logic        res_last;

    logic                                psel    = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite  = 1'b0;
    logic [crpr_pkg::CFG_ADDR_BITS-1:0]  paddr   = '0;
    logic [crpr_pkg::CFG_DATA_BITS-1:0]  pwdata  = '0;
    logic [crpr_pkg::CFG_DATA_BITS-1:0]  prdata;
    logic                                pready;

    // Stimulus-side copy of what was last written, used to aim pixel values
    logic [11:0] img_w;
    logic [15:0] img_h;
    logic [31:0] thr_c, thr_s, magic_v;

    bit          idle_on     = 1'b1;
    int unsigned items_sent  = 0;
    int          pending;
    int          mismatches;
    int          quiet       = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    cosmic_ray_pixel_rejector i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (px_valid),
        .o_ready        (px_ready),
        .i_command      (px_command),
        .i_pixel_in     (px_data),
        .o_valid        (res_valid),
        .i_ready        (res_ready),
        .o_pixel_out    (res_pixel),
        .o_was_replaced (res_replaced),
        .o_last_of_image(res_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    crpr_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_px_valid    (px_valid),
        .i_px_ready    (px_ready),
        .i_px_command  (px_command),
        .i_px_data     (px_data),
        .i_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .i_res_pixel   (res_pixel),
        .i_res_replaced(res_replaced),
        .i_res_last    (res_last),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_pending     (pending),
        .o_errors      (mismatches)
    );

    // Watchdog: end the run if neither channel moves for too long. The
    // longest quiet stretch of a correct run is a register load after a drain.
    always @(posedge i_clk) begin
        if ((px_valid && px_ready) || (res_valid && res_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // Result side: draw a stall before each result, then hold ready until
    // the transfer. Ready stays high across results when no stall is drawn.
    initial begin
        int unsigned stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = idle_on ? $urandom_range(0, 7) : 0;
            if (stall != 0) begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ready <= 1'b1;
            @(posedge i_clk);
            while (!(res_valid && res_ready)) @(posedge i_clk);
        end
    end

    // One register write: setup cycle, access cycle, then a bus-idle cycle
    // so that back-to-back writes never move psel twice in one step.
    task automatic cfg_write(input crpr_pkg::t_reg_idx idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_registers(input logic [11:0] w, input logic [15:0] h,
                                  input logic [31:0] c, input logic [31:0] s,
                                  input logic [3:0] n, input logic [31:0] m);
        img_w   = w;
        img_h   = h;
        thr_c   = c;
        thr_s   = s;
        magic_v = m;
        cfg_write(crpr_pkg::REG_IMAGE_WIDTH,  32'(w));
        cfg_write(crpr_pkg::REG_IMAGE_HEIGHT, 32'(h));
        cfg_write(crpr_pkg::REG_CENTRE_THR,   c);
        cfg_write(crpr_pkg::REG_SURROUND_THR, s);
        cfg_write(crpr_pkg::REG_MIN_GOOD,     32'(n));
        cfg_write(crpr_pkg::REG_MAGIC_VALUE,  m);
    endtask

    // Present one pixel-channel transfer; returns at the accepting edge.
    // Valid is lowered only when a gap is drawn, so it never toggles within
    // a step.
    task automatic push_item(input logic cmd, input logic [31:0] pix);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            px_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        px_valid   <= 1'b1;
        px_command <= cmd;
        px_data    <= pix;
        @(posedge i_clk);
        while (!px_ready) @(posedge i_clk);
    endtask

    // Hold the sender until every predicted result has left, then give the
    // pipeline time to finish any item that releases nothing.
    task automatic settle();
        px_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Pixel values clustered on the thresholds and the blank value, with
    // plain random words for full bit coverage.
    function automatic logic [31:0] pick_pixel();
        case ($urandom_range(0, 7))
            0:       return magic_v;
            1:       return thr_c;
            2:       return thr_s;
            3:       return thr_s - 32'd1;
            4:       return thr_c + 32'($urandom_range(0, 255));
            5:       return thr_s - 32'($urandom_range(1, 255));
            default: return $urandom;
        endcase
    endfunction

    // A whole image at the current geometry plus its drain flushes. With
    // noise on, scatter early flushes among the pixels and stray pixels
    // among the drain; the block must ignore both.
    task automatic send_image(input bit noisy);
        int unsigned w, h;
        w = (img_w == 0) ? 1 : (img_w > 2048) ? 2048 : img_w;
        h = (img_h == 0) ? 1 : img_h;
        for (int unsigned p = 0; p < w * h; p++) begin
            if (noisy && $urandom_range(0, 15) == 0)
                push_item(crpr_pkg::CMD_FLUSH, $urandom);
            push_item(crpr_pkg::CMD_PIXEL, pick_pixel());
        end
        for (int unsigned f = 0; f <= w; f++) begin
            if (noisy && $urandom_range(0, 7) == 0)
                push_item(crpr_pkg::CMD_PIXEL, pick_pixel());
            push_item(crpr_pkg::CMD_FLUSH, $urandom);
        end
        items_sent += w * h + w + 1;
    endtask

    initial begin
        int unsigned first_random;
        logic [11:0] w;
        logic [15:0] h;
        logic [31:0] c, s, m;
        logic [3:0]  n;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 3x3 image: hot centre with five cold neighbours and a blank one,
        // a pixel exactly at the centre threshold, one exactly at the
        // surround threshold; flush while idle, early flush, late pixel.
        load_registers(12'd3, 16'd3, CENTRE_LEVEL, SURROUND_LEVEL, 4'd4,
                       crpr_pkg::MAGIC_RST);
        push_item(crpr_pkg::CMD_FLUSH, 32'hFFFF_FFFF);
        push_item(crpr_pkg::CMD_PIXEL, COLD_PX);
        push_item(crpr_pkg::CMD_PIXEL, COLD_PX);
        push_item(crpr_pkg::CMD_FLUSH, 32'h0000_0000);
        push_item(crpr_pkg::CMD_PIXEL, COLD_PX);
        push_item(crpr_pkg::CMD_PIXEL, COLD_PX);
        push_item(crpr_pkg::CMD_PIXEL, HOT_PX);
        push_item(crpr_pkg::CMD_PIXEL, crpr_pkg::MAGIC_RST);
        push_item(crpr_pkg::CMD_PIXEL, CENTRE_LEVEL);
        push_item(crpr_pkg::CMD_PIXEL, COLD_PX);
        push_item(crpr_pkg::CMD_PIXEL, SURROUND_LEVEL);
        push_item(crpr_pkg::CMD_PIXEL, HOT_PX);
        repeat (4) push_item(crpr_pkg::CMD_FLUSH, $urandom);
        settle();

        // Single row, zero neighbours needed: every candidate goes
        load_registers(12'd4, 16'd1, CENTRE_LEVEL, SURROUND_LEVEL, 4'd0,
                       crpr_pkg::MAGIC_RST);
        push_item(crpr_pkg::CMD_PIXEL, 32'h7FFF_FFFF);
        push_item(crpr_pkg::CMD_PIXEL, COLD_PX);
        push_item(crpr_pkg::CMD_PIXEL, HOT_PX);
        push_item(crpr_pkg::CMD_PIXEL, 32'h8000_0001);
        repeat (5) push_item(crpr_pkg::CMD_FLUSH, $urandom);
        settle();

        // Zero width and height act as one; nine neighbours never replace
        load_registers(12'd0, 16'd0, CENTRE_LEVEL, SURROUND_LEVEL, 4'd9, 32'h0);
        push_item(crpr_pkg::CMD_PIXEL, HOT_PX);
        repeat (2) push_item(crpr_pkg::CMD_FLUSH, $urandom);
        settle();

        // Random phases: small images under random settings, reprogrammed
        // only once the previous phase has fully drained
        first_random = items_sent;
        while (items_sent - first_random < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       w = 12'd0;
                1:       w = 12'd1;
                2:       w = 12'd2;
                default: w = 12'($urandom_range(3, 8));
            endcase
            case ($urandom_range(0, 5))
                0:       h = 16'd0;
                1:       h = 16'd1;
                default: h = 16'($urandom_range(2, 6));
            endcase
            case ($urandom_range(0, 5))
                0: begin
                    c = 32'h7FFF_FFFF;
                    s = 32'h8000_0000;
                end
                1: begin
                    c = 32'h8000_0000;
                    s = 32'h7FFF_FFFF;
                end
                default: begin
                    s = $urandom;
                    c = s + 32'($urandom_range(0, 32'h0010_0000));
                end
            endcase
            n = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(9, 15))
                                            : 4'($urandom_range(0, 8));
            case ($urandom_range(0, 4))
                0:       m = 32'h8000_0000;
                1:       m = 32'h7FFF_FFFF;
                2:       m = 32'h0;
                default: m = $urandom;
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
            load_registers(w, h, c, s, n, m);
            repeat ($urandom_range(1, 3)) begin
                // a flush between images finds the block idle: ignored
                if ($urandom_range(0, 3) == 0) push_item(crpr_pkg::CMD_FLUSH, $urandom);
                send_image(1'b1);
            end
            settle();
        end

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
